// ===== sv/led_matrix_frame_serializer_assert.svh =====
`ifndef LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH
`define LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LMFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define LMFS_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

// ===== sv/lmfs_pkg.sv =====
package lmfs_pkg;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] pixel_x;
        logic [2:0] pixel_y;
        logic       pixel_value;
        logic       clear_after;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       latch;
        logic       led_state;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic we;
        logic wipe;
    } t_store_ctl;

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_FLUSH  = 3'd4;

    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [3:0] REG_SHUTDOWN   = 4'hC;
    localparam logic [3:0] REG_SCANLIMIT  = 4'hB;
    localparam logic [7:0] DATA_NORMAL_OP = 8'h01;
    localparam logic [7:0] DATA_SCAN_ALL  = 8'h07;

    localparam logic [3:0] GROUPS_INIT  = 4'd2;
    localparam logic [3:0] GROUPS_CLEAR = 4'd9;
    localparam logic [3:0] GROUPS_FLUSH = 4'd8;

    localparam logic [2:0] CFG_MODULES_RESET = 3'd4;

endpackage

// ===== sv/lmfs_ram.sv =====
module lmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lmfs_frame_store.sv =====
`include "led_matrix_frame_serializer_assert.svh"

module lmfs_frame_store
    import lmfs_pkg::*;
#(
    parameter int MAX_MODULES = 4,
    parameter int AW          = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_store_ctl           i_ctl,
    input  logic [2:0]           i_live,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [7:0]           o_rd_data,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data
);

    localparam int DEPTH = MAX_MODULES * 8;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic             r_rd_vld;
    logic             n_rd_vld;
    logic [7:0]       ram_data;

    lmfs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_ctl.we),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_data)
    );

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.wipe) begin
            for (int i = 0; i < DEPTH; i++) begin
                if ((i >> 3) < int'(i_live)) begin
                    n_vld[i] = 1'b0;
                end
            end
        end else if (i_ctl.we) begin
            n_vld[i_wr_addr] = 1'b1;
        end
        n_rd_vld = (int'(i_rd_addr) < DEPTH) ? r_vld[i_rd_addr] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_rd_vld <= n_rd_vld;
        end
    end

    // never-written rows read as blank
    assign o_rd_data = r_rd_vld ? ram_data : 8'h00;

    `LMFS_ASSERT(a_wr_in_range, i_ctl.we |-> int'(i_wr_addr) < DEPTH, "write beyond frame")
    `LMFS_ASSERT(a_wr_wipe_apart, !(i_ctl.we && i_ctl.wipe), "write during wipe")
    `LMFS_ASSERT_NEXT(a_vld_after_wr, i_ctl.we, r_vld[$past(i_wr_addr)], "row not marked")

endmodule

// ===== sv/led_matrix_frame_serializer.sv =====
// Frame serializer for a daisy chain of 8x8 LED matrix driver modules.
// Input channel: i_in_valid / o_in_stall with an item in i_in_data. Output
// channel: o_out_valid / i_out_stall with a word in o_out_data. A transfer
// happens on an edge with valid high and stall low.
// One item is processed at a time; o_in_stall is high while it runs.
// Set pixel reads the row, then writes it back. Toggle does the same, then
// emits a reply with the new LED state. Init, clear and flush emit 2, 9
// and 8 groups of n words (n = modules in use), one word per cycle while
// the output is not stalled. Flush rows come from the frame memory, read
// ahead of the word through its registered read port.
// The output register lets the last word wait while the next item is
// taken. A stall on the output holds the current word and pauses the
// sequence; nothing is dropped.
// Reset clears control state, sets the module count to 4 and marks every
// frame row blank at once; no clearing pass is needed.
// Write the module count through i_cfg_we / i_cfg_wdata only while idle.
`include "led_matrix_frame_serializer_assert.svh"

module led_matrix_frame_serializer
    import lmfs_pkg::*;
#(
    parameter int MAX_MODULES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata
);

    localparam int MODW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int AW   = MODW + 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_REPLY,
        S_RUN
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_cfg;
    logic [2:0]      r_cmd, n_cmd;
    logic            r_clr, n_clr;
    logic            r_val, n_val;
    logic [2:0]      r_col, n_col;
    logic            r_inside, n_inside;
    logic            r_led, n_led;
    logic [MODW-1:0] r_mod, n_mod;
    logic [3:0]      r_row, n_row;
    logic [3:0]      r_groups, n_groups;
    t_out_item       r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic [2:0]      live;
    logic            out_free;
    logic            mod_last;
    logic            grp_last;
    logic [7:0]      rd_data;
    logic [7:0]      new_byte;
    logic [2:0]      bit_pos;
    t_store_ctl      ctl;

    always_comb begin
        live = r_cfg;
        if (live == 3'd0) begin
            live = 3'd1;
        end
        if (live > 3'(MAX_MODULES)) begin
            live = 3'(MAX_MODULES);
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;
    assign mod_last = (3'(r_mod) == live - 3'd1);
    assign grp_last = (r_row == r_groups - 4'd1);
    assign bit_pos  = 3'd7 - r_col;

    always_comb begin
        new_byte = rd_data;
        if (r_cmd == CMD_TOGGLE) begin
            new_byte[bit_pos] = ~rd_data[bit_pos];
        end else begin
            new_byte[bit_pos] = r_val;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_clr     = r_clr;
        n_val     = r_val;
        n_col     = r_col;
        n_inside  = r_inside;
        n_led     = r_led;
        n_mod     = r_mod;
        n_row     = r_row;
        n_groups  = r_groups;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.cmd;
                    n_clr    = i_in_data.clear_after;
                    n_val    = i_in_data.pixel_value;
                    n_col    = i_in_data.pixel_x[2:0];
                    n_inside = (i_in_data.pixel_x[5:3] < live);
                    n_mod    = '0;
                    n_row    = 4'd0;
                    case (i_in_data.cmd)
                        CMD_INIT: begin
                            n_groups = GROUPS_INIT;
                            n_state  = S_RUN;
                        end
                        CMD_CLEAR: begin
                            n_groups = GROUPS_CLEAR;
                            n_state  = S_RUN;
                            ctl.wipe = 1'b1;
                        end
                        CMD_FLUSH: begin
                            n_groups = GROUPS_FLUSH;
                            n_state  = S_RUN;
                        end
                        CMD_SET, CMD_TOGGLE: begin
                            n_mod   = MODW'(i_in_data.pixel_x[5:3]);
                            n_row   = {1'b0, i_in_data.pixel_y};
                            n_state = S_MOD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                ctl.we = r_inside;
                n_led  = r_inside && new_byte[bit_pos];
                if (r_cmd == CMD_TOGGLE) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_out.kind      = KIND_REPLY;
                    n_out.reg_addr  = 4'd0;
                    n_out.reg_data  = 8'd0;
                    n_out.latch     = 1'b0;
                    n_out.led_state = r_led;
                    n_out.last      = 1'b1;
                    n_out_vld       = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out.kind      = KIND_WORD;
                    n_out.latch     = mod_last;
                    n_out.led_state = 1'b0;
                    n_out.last      = mod_last && grp_last;
                    case (r_cmd)
                        CMD_INIT: begin
                            n_out.reg_addr = (r_row == 4'd0) ? REG_SHUTDOWN : REG_SCANLIMIT;
                            n_out.reg_data = (r_row == 4'd0) ? DATA_NORMAL_OP : DATA_SCAN_ALL;
                        end
                        CMD_FLUSH: begin
                            n_out.reg_addr = r_row + 4'd1;
                            n_out.reg_data = rd_data;
                        end
                        default: begin
                            n_out.reg_addr = r_row;
                            n_out.reg_data = 8'd0;
                        end
                    endcase
                    n_out_vld = 1'b1;
                    if (mod_last && grp_last) begin
                        n_state  = S_IDLE;
                        ctl.wipe = (r_cmd == CMD_FLUSH) && r_clr;
                    end else if (mod_last) begin
                        n_mod = '0;
                        n_row = r_row + 4'd1;
                    end else begin
                        n_mod = r_mod + MODW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_MODULES_RESET;
            r_out_vld <= 1'b0;
            r_mod     <= '0;
            r_row     <= 4'd0;
            r_groups  <= 4'd0;
            r_cmd     <= CMD_INIT;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_mod     <= n_mod;
            r_row     <= n_row;
            r_groups  <= n_groups;
            r_cmd     <= n_cmd;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
        r_clr    <= n_clr;
        r_val    <= n_val;
        r_col    <= n_col;
        r_inside <= n_inside;
        r_led    <= n_led;
        r_out    <= n_out;
    end

    lmfs_frame_store #(
        .MAX_MODULES (MAX_MODULES),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_live    (live),
        .i_rd_addr ({n_mod, n_row[2:0]}),
        .o_rd_data (rd_data),
        .i_wr_addr ({r_mod, r_row[2:0]}),
        .i_wr_data (new_byte)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `LMFS_ASSERT_NEXT(a_mod_once, r_state == S_MOD, r_state != S_MOD, "row written twice")
    `LMFS_ASSERT(a_run_bound, r_state == S_RUN |-> r_row < r_groups, "group count overrun")
    `LMFS_ASSERT(a_last_latch, r_out_vld && r_out.last && !r_out.kind |-> r_out.latch, "open group")

endmodule
